### hw/rtl/cilp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cilp_pkg
// Shared constants and types for the C integer literal parser.
// ----------------------------------------------------------------------------
package cilp_pkg;

  localparam int VALUE_WIDTH  = 32;
  localparam int RESULT_WIDTH = 32;
  localparam int ACC_WIDTH    = VALUE_WIDTH + 4;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SEVEN   = 8'h37;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_UP_L    = 8'h4C;
  localparam logic [7:0] CH_UP_U    = 8'h55;
  localparam logic [7:0] CH_UP_X    = 8'h58;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_F    = 8'h66;
  localparam logic [7:0] CH_LO_L    = 8'h6C;
  localparam logic [7:0] CH_LO_U    = 8'h75;
  localparam logic [7:0] CH_LO_X    = 8'h78;

  typedef enum logic [1:0] {
    RAD_DEC = 2'd0,
    RAD_OCT = 2'd1,
    RAD_HEX = 2'd2
  } radix_t;

  typedef struct packed {
    logic       is_nul;
    logic       is_space;
    logic       is_plus;
    logic       is_minus;
    logic       is_x;
    logic       is_long;
    logic       is_uns;
    logic       is_zero;
    logic       dec_ok;
    logic       oct_ok;
    logic       hex_ok;
    logic [3:0] dval;
    logic       last;
  } chr_class_t;

endpackage

### hw/rtl/cilp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cilp_front
// Decodes each incoming byte into character classes and a digit value.
// ----------------------------------------------------------------------------
module cilp_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           char_code,
  input  logic                 last_char,
  input  logic                 q_full,
  output logic                 push,
  output cilp_pkg::chr_class_t cls
);
  import cilp_pkg::*;

  logic is_dec;
  logic is_hex_lo;
  logic is_hex_up;

  assign is_dec    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_hex_lo = (char_code >= CH_LO_A) && (char_code <= CH_LO_F);
  assign is_hex_up = (char_code >= CH_UP_A) && (char_code <= CH_UP_F);

  always_comb begin
    cls.is_nul   = (char_code == CH_NUL);
    cls.is_space = (char_code == CH_SPACE) || (char_code == CH_NEWLINE);
    cls.is_plus  = (char_code == CH_PLUS);
    cls.is_minus = (char_code == CH_MINUS);
    cls.is_x     = (char_code == CH_LO_X) || (char_code == CH_UP_X);
    cls.is_long  = (char_code == CH_LO_L) || (char_code == CH_UP_L);
    cls.is_uns   = (char_code == CH_LO_U) || (char_code == CH_UP_U);
    cls.is_zero  = (char_code == CH_ZERO);
    cls.dec_ok   = is_dec;
    cls.oct_ok   = (char_code >= CH_ZERO) && (char_code <= CH_SEVEN);
    cls.hex_ok   = is_dec || is_hex_lo || is_hex_up;
    cls.dval     = is_dec ? char_code[3:0] : char_code[3:0] + 4'd9;
    cls.last     = last_char;
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

endmodule

### hw/rtl/cilp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cilp_queue
// Two-entry queue of decoded characters between the front and back parts.
// ----------------------------------------------------------------------------
module cilp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cilp_pkg::chr_class_t push_data,
  input  logic                 pop,
  output logic                 full,
  output logic                 head_valid,
  output cilp_pkg::chr_class_t head
);
  import cilp_pkg::*;

  chr_class_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];

endmodule

### hw/rtl/cilp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cilp_back
// Literal state machine, radix accumulator and result register.
// ----------------------------------------------------------------------------
module cilp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  cilp_pkg::chr_class_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 valid_res,
  output logic signed [cilp_pkg::RESULT_WIDTH-1:0] value,
  output logic [1:0]           radix_code,
  output logic                 long_suffix,
  output logic                 unsigned_suffix,
  output logic                 overflowed
);
  import cilp_pkg::*;

  typedef enum logic [7:0] {
    PH_LEAD   = 8'b0000_0001,
    PH_SIGNED = 8'b0000_0010,
    PH_ZERO   = 8'b0000_0100,
    PH_HEXPFX = 8'b0000_1000,
    PH_BODY   = 8'b0001_0000,
    PH_TRAIL  = 8'b0010_0000,
    PH_ERR    = 8'b0100_0000,
    PH_ENDOK  = 8'b1000_0000
  } phase_t;

  phase_t                 phase;
  radix_t                 radix;
  logic                   negative;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic                   long_seen;
  logic                   unsigned_seen;
  logic                   digit_seen;
  logic                   overflow_seen;

  phase_t                 phase_next;
  radix_t                 radix_next;
  logic                   negative_next;
  logic [VALUE_WIDTH-1:0] magnitude_next;
  logic                   long_seen_next;
  logic                   unsigned_seen_next;
  logic                   digit_seen_next;
  logic                   overflow_seen_next;

  logic                   res_valid;
  logic [RESULT_WIDTH-1:0] res_value;
  logic [1:0]             res_radix;
  logic                   res_long;
  logic                   res_uns;
  logic                   res_ovf;

  logic                   out_ready;
  logic                   acc_en;
  logic [3:0]             acc_d;
  logic [ACC_WIDTH-1:0]   mag_x;
  logic [ACC_WIDTH-1:0]   acc_sum;
  logic                   accept_now;
  logic                   accept_next;
  logic [VALUE_WIDTH-1:0] signed_mag;

  assign out_ready = !out_valid || !out_stall;
  assign pop       = head_valid && (!head.last || out_ready);

  assign accept_now = digit_seen && ((phase == PH_ZERO) || (phase == PH_BODY) ||
                                     (phase == PH_TRAIL) || (phase == PH_ENDOK));

  always_comb begin
    phase_next         = phase;
    radix_next         = radix;
    negative_next      = negative;
    long_seen_next     = long_seen;
    unsigned_seen_next = unsigned_seen;
    digit_seen_next    = digit_seen;
    acc_en             = 1'b0;
    acc_d              = head.dval;

    if ((phase == PH_ERR) || (phase == PH_ENDOK)) begin
      phase_next = phase;
    end else if (head.is_nul) begin
      phase_next = accept_now ? PH_ENDOK : PH_ERR;
    end else begin
      case (phase)
        PH_LEAD, PH_SIGNED: begin
          if ((phase == PH_LEAD) && head.is_space) begin
            phase_next = phase;
          end else if ((phase == PH_LEAD) && (head.is_plus || head.is_minus)) begin
            negative_next = head.is_minus;
            phase_next    = PH_SIGNED;
          end else if (head.is_zero) begin
            digit_seen_next = 1'b1;
            phase_next      = PH_ZERO;
          end else if (head.dec_ok) begin
            radix_next = RAD_DEC;
            acc_en     = 1'b1;
            phase_next = PH_BODY;
          end else begin
            phase_next = PH_ERR;
          end
        end
        PH_ZERO: begin
          if (head.is_x) begin
            radix_next      = RAD_HEX;
            digit_seen_next = 1'b0;
            phase_next      = PH_HEXPFX;
          end else if (head.oct_ok) begin
            radix_next = RAD_OCT;
            acc_en     = 1'b1;
            phase_next = PH_BODY;
          end else if (head.is_long) begin
            long_seen_next = 1'b1;
            phase_next     = long_seen ? PH_ERR : PH_BODY;
          end else if (head.is_uns) begin
            unsigned_seen_next = 1'b1;
            phase_next         = (negative || unsigned_seen) ? PH_ERR : PH_BODY;
          end else if (head.is_space) begin
            phase_next = PH_TRAIL;
          end else begin
            phase_next = PH_ERR;
          end
        end
        PH_HEXPFX: begin
          if (head.hex_ok) begin
            acc_en     = 1'b1;
            phase_next = PH_BODY;
          end else begin
            phase_next = PH_ERR;
          end
        end
        PH_BODY: begin
          if (head.is_long) begin
            long_seen_next = 1'b1;
            if (long_seen) begin
              phase_next = PH_ERR;
            end
          end else if (head.is_uns) begin
            unsigned_seen_next = 1'b1;
            if (negative || unsigned_seen) begin
              phase_next = PH_ERR;
            end
          end else if (head.is_space) begin
            phase_next = PH_TRAIL;
          end else if (long_seen || unsigned_seen) begin
            phase_next = PH_ERR;
          end else begin
            case (radix)
              RAD_OCT: acc_en = head.oct_ok;
              RAD_HEX: acc_en = head.hex_ok;
              default: acc_en = head.dec_ok;
            endcase
            if (!acc_en) begin
              phase_next = PH_ERR;
            end
          end
        end
        PH_TRAIL: begin
          if (!head.is_space) begin
            phase_next = PH_ERR;
          end
        end
        default: begin
          phase_next = PH_ERR;
        end
      endcase
    end

    if (acc_en) begin
      digit_seen_next = 1'b1;
    end
  end

  always_comb begin
    mag_x = {4'b0000, magnitude};
    case (radix_next)
      RAD_HEX: acc_sum = (mag_x << 4) + ACC_WIDTH'(acc_d);
      RAD_OCT: acc_sum = (mag_x << 3) + ACC_WIDTH'(acc_d);
      default: acc_sum = (mag_x << 3) + (mag_x << 1) + ACC_WIDTH'(acc_d);
    endcase
    if (acc_en) begin
      magnitude_next     = acc_sum[VALUE_WIDTH-1:0];
      overflow_seen_next = overflow_seen || (|acc_sum[ACC_WIDTH-1:VALUE_WIDTH]);
    end else begin
      magnitude_next     = magnitude;
      overflow_seen_next = overflow_seen;
    end
  end

  assign accept_next = digit_seen_next &&
                       ((phase_next == PH_ZERO) || (phase_next == PH_BODY) ||
                        (phase_next == PH_TRAIL) || (phase_next == PH_ENDOK));
  assign signed_mag  = negative_next ? (VALUE_WIDTH'(0) - magnitude_next) : magnitude_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEAD;
      radix         <= RAD_DEC;
      negative      <= 1'b0;
      magnitude     <= '0;
      long_seen     <= 1'b0;
      unsigned_seen <= 1'b0;
      digit_seen    <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (pop) begin
      if (head.last) begin
        phase         <= PH_LEAD;
        radix         <= RAD_DEC;
        negative      <= 1'b0;
        magnitude     <= '0;
        long_seen     <= 1'b0;
        unsigned_seen <= 1'b0;
        digit_seen    <= 1'b0;
        overflow_seen <= 1'b0;
      end else begin
        phase         <= phase_next;
        radix         <= radix_next;
        negative      <= negative_next;
        magnitude     <= magnitude_next;
        long_seen     <= long_seen_next;
        unsigned_seen <= unsigned_seen_next;
        digit_seen    <= digit_seen_next;
        overflow_seen <= overflow_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= pop && head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && pop && head.last) begin
      res_valid <= accept_next;
      res_value <= accept_next ? RESULT_WIDTH'(signed_mag) : '0;
      res_radix <= accept_next ? radix_next : RAD_DEC;
      res_long  <= accept_next && long_seen_next;
      res_uns   <= accept_next && unsigned_seen_next;
      res_ovf   <= accept_next && overflow_seen_next;
    end
  end

  assign valid_res       = res_valid;
  assign value           = $signed(res_value);
  assign radix_code      = res_radix;
  assign long_suffix     = res_long;
  assign unsigned_suffix = res_uns;
  assign overflowed      = res_ovf;

endmodule

### hw/rtl/c_integer_literal_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_integer_literal_parser
// Streaming parser of C integer literals, one character per beat.
// ----------------------------------------------------------------------------
// The block takes one byte of text per beat and sustains one beat per clock
// cycle while in_stall is low; in_stall rises when the queue is full. One
// result beat is registered for each beat marked last_char, as that beat is
// popped from the queue and the output is not stalled. Each character costs a
// shift-and-add multiply of the magnitude by the literal's radix, and a
// two-entry queue buffers characters between the decoder and state machine.
// A result with valid_res low carries zero in every other field.
module c_integer_literal_parser (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [7:0]                               char_code,
  input  logic                                     last_char,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic                                     valid_res,
  output logic signed [cilp_pkg::RESULT_WIDTH-1:0] value,
  output logic [1:0]                               radix_code,
  output logic                                     long_suffix,
  output logic                                     unsigned_suffix,
  output logic                                     overflowed
);
  import cilp_pkg::*;

  chr_class_t front_cls;
  chr_class_t q_head;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_head_valid;

  cilp_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .last_char (last_char),
    .q_full    (q_full),
    .push      (push),
    .cls       (front_cls)
  );

  cilp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (front_cls),
    .pop        (pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  cilp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (q_head_valid),
    .head            (q_head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .valid_res       (valid_res),
    .value           (value),
    .radix_code      (radix_code),
    .long_suffix     (long_suffix),
    .unsigned_suffix (unsigned_suffix),
    .overflowed      (overflowed)
  );

`ifndef SYNTHESIS
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !valid_res) |->
      (value == '0) && (radix_code == RAD_DEC) && !long_suffix &&
      !unsigned_suffix && !overflowed)
    else $error("rejected literal carries nonzero result fields");

  a_radix_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (radix_code == RAD_DEC) || (radix_code == RAD_OCT) ||
                  (radix_code == RAD_HEX))
    else $error("illegal radix code on result");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pop && q_head.last))
    else $error("result appeared without a final character");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !q_head_valid |-> !in_stall)
    else $error("input stalled while the queue is empty");
`endif

endmodule
